@@ design/bldc_pkg.sv @@
package bldc_pkg;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_CAPTURE = 2'd1,
    CMD_HALL    = 2'd2,
    CMD_IDLE    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_PULSE_CENTRE   = 3'd0,
    REG_CURRENT_LIMIT  = 3'd1,
    REG_TRIP_COUNT     = 3'd2,
    REG_RECOVER_COUNT  = 3'd3,
    REG_TEMP_THRESHOLD = 3'd4,
    REG_FAN_COUNT      = 3'd5,
    REG_SIGNAL_TIMEOUT = 3'd6,
    REG_STALL_CHECK    = 3'd7
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] HallWrap = 16'd60000;
  localparam logic [7:0]  DutyOff  = 8'hFF;

  typedef struct packed {
    logic [15:0] pulse_centre;
    logic [9:0]  current_limit;
    logic [14:0] trip_count;
    logic [14:0] recover_count;
    logic [9:0]  temp_threshold;
    logic [14:0] fan_count;
    logic [15:0] signal_timeout;
    logic [4:0]  stall_check;
  } cfg_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] pulse_width;
    logic [2:0]  hall_state;
    logic [7:0]  current_sample;
    logic [7:0]  temp_sample;
  } item_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       reverse;
    logic [1:0] high_phase;
    logic [1:0] low_phase;
    logic       brake;
    logic       fan_on;
    logic       drive_enabled;
    logic       start_request;
  } result_t;

  // throttle curve: fine steps near zero, steep top end, saturates at off
  function automatic logic [7:0] curve_lookup(input logic [7:0] idx);
    logic [8:0] half;
    begin
      half = ({1'b0, idx} + 9'd7) >> 1;
      if (idx < 8'd5) begin
        curve_lookup = idx + 8'd1;
      end else if (idx < 8'd15) begin
        curve_lookup = half[7:0];
      end else if (idx < 8'd242) begin
        curve_lookup = idx - 8'd4;
      end else if (idx < 8'd250) begin
        curve_lookup = {idx[6:0], 1'b0} - 8'd245;
      end else begin
        curve_lookup = DutyOff;
      end
    end
  endfunction

  // six-step commutation: high phase in [3:2], low phase in [1:0], 0 invalid
  function automatic logic [3:0] step_code(input logic rev, input logic [2:0] hs);
    begin
      case (hs)
        3'd1:    step_code = rev ? 4'hD : 4'h7;
        3'd2:    step_code = rev ? 4'hB : 4'hE;
        3'd3:    step_code = rev ? 4'h9 : 4'h6;
        3'd4:    step_code = rev ? 4'h6 : 4'h9;
        3'd5:    step_code = rev ? 4'hE : 4'hB;
        3'd6:    step_code = rev ? 4'h7 : 4'hD;
        default: step_code = 4'h0;
      endcase
    end
  endfunction

endpackage

@@ design/bldc_cfg.sv @@
module bldc_cfg import bldc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_PULSE_CENTRE:   cfg_d.pulse_centre   = cfg_data_i;
        REG_CURRENT_LIMIT:  cfg_d.current_limit  = cfg_data_i[9:0];
        REG_TRIP_COUNT:     cfg_d.trip_count     = cfg_data_i[14:0];
        REG_RECOVER_COUNT:  cfg_d.recover_count  = cfg_data_i[14:0];
        REG_TEMP_THRESHOLD: cfg_d.temp_threshold = cfg_data_i[9:0];
        REG_FAN_COUNT:      cfg_d.fan_count      = cfg_data_i[14:0];
        REG_SIGNAL_TIMEOUT: cfg_d.signal_timeout = cfg_data_i;
        REG_STALL_CHECK:    cfg_d.stall_check    = cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_centre   <= 16'd1500;
      cfg_q.current_limit  <= 10'd720;
      cfg_q.trip_count     <= 15'd650;
      cfg_q.recover_count  <= 15'd20000;
      cfg_q.temp_threshold <= 10'd362;
      cfg_q.fan_count      <= 15'd2000;
      cfg_q.signal_timeout <= 16'd12000;
      cfg_q.stall_check    <= 5'd4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/bldc_core.sv @@
module bldc_core import bldc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  logic [15:0]        hall_cnt_q, hall_cnt_d;
  logic [15:0]        last_hall_q, last_hall_d;
  logic               stalled_q, stalled_d;
  logic [3:0]         pulse_cnt_q, pulse_cnt_d;
  logic [15:0]        held_q, held_d;
  logic               new_pulse_q, new_pulse_d;
  logic               enabled_q, enabled_d;
  logic signed [15:0] cur_cnt_q, cur_cnt_d;
  logic signed [15:0] fan_cnt_q, fan_cnt_d;
  logic [15:0]        lost_q, lost_d;
  logic [7:0]         duty_q, duty_d;
  logic               dir_q, dir_d;
  logic [3:0]         phase_q, phase_d;
  logic               brake_q, brake_d;
  logic               fan_q, fan_d;
  logic               start;

  logic [3:0]         code;
  logic [3:0]         check_at;
  logic [16:0]        offset;
  logic [16:0]        offset_abs;
  logic [7:0]         mag;
  logic [7:0]         curve_val;
  logic [9:0]         curr_scaled;
  logic [9:0]         temp_scaled;
  logic signed [16:0] cur_ext;
  logic signed [16:0] fan_ext;
  logic signed [16:0] trip_lim;
  logic signed [16:0] recover_lim;
  logic signed [16:0] fan_up_lim;
  logic signed [16:0] fan_dn_lim;
  logic [15:0]        lost_base;
  logic               lost_fire;

  assign code = step_code(dir_q, item_i.hall_state);

  always_comb begin
    if (cfg_i.stall_check == 5'd0) begin
      check_at = 4'd0;
    end else if (cfg_i.stall_check > 5'd16) begin
      check_at = 4'd15;
    end else begin
      check_at = 4'(cfg_i.stall_check - 5'd1);
    end
  end

  assign offset     = {1'b0, held_q} - {1'b0, cfg_i.pulse_centre};
  assign offset_abs = offset[16] ? (17'd0 - offset) : offset;
  assign mag        = (|offset_abs[16:9]) ? 8'hFF : offset_abs[8:1];
  assign curve_val  = curve_lookup(~mag);

  assign curr_scaled = {item_i.current_sample, 2'b00};
  assign temp_scaled = {item_i.temp_sample, 2'b00};
  assign cur_ext     = 17'(cur_cnt_q);
  assign fan_ext     = 17'(fan_cnt_q);
  assign trip_lim    = $signed({2'b00, cfg_i.trip_count});
  assign recover_lim = $signed(17'd0 - {2'b00, cfg_i.recover_count});
  assign fan_up_lim  = $signed({2'b00, cfg_i.fan_count});
  assign fan_dn_lim  = $signed(17'd0 - {2'b00, cfg_i.fan_count});

  always_comb begin
    hall_cnt_d  = hall_cnt_q;
    last_hall_d = last_hall_q;
    stalled_d   = stalled_q;
    pulse_cnt_d = pulse_cnt_q;
    held_d      = held_q;
    new_pulse_d = new_pulse_q;
    enabled_d   = enabled_q;
    cur_cnt_d   = cur_cnt_q;
    fan_cnt_d   = fan_cnt_q;
    lost_d      = lost_q;
    duty_d      = duty_q;
    dir_d       = dir_q;
    phase_d     = phase_q;
    brake_d     = brake_q;
    fan_d       = fan_q;
    start       = 1'b0;
    lost_base   = lost_q;
    lost_fire   = 1'b0;

    case (item_i.cmd)
      CMD_HALL: begin
        hall_cnt_d = hall_cnt_q + 16'd1;
        if (code != 4'h0) begin
          phase_d = code;
          brake_d = 1'b0;
        end
      end
      CMD_CAPTURE: begin
        held_d = item_i.pulse_width;
        if (pulse_cnt_q >= check_at) begin
          if (last_hall_q == hall_cnt_q) begin
            stalled_d = 1'b1;
          end else begin
            last_hall_d = hall_cnt_q;
            stalled_d   = 1'b0;
          end
          pulse_cnt_d = 4'd0;
        end else begin
          pulse_cnt_d = pulse_cnt_q + 4'd1;
        end
        if (hall_cnt_q > HallWrap) begin
          hall_cnt_d = 16'd0;
        end
        new_pulse_d = 1'b1;
      end
      CMD_TICK: begin
        if (new_pulse_q && enabled_q) begin
          new_pulse_d = 1'b0;
          dir_d       = offset[16];
          if (stalled_q && curve_val != DutyOff) begin
            start       = 1'b1;
            stalled_d   = 1'b0;
            pulse_cnt_d = 4'd0;
          end
          duty_d = curve_val;
          if (curve_val == DutyOff) begin
            brake_d = 1'b1;
            phase_d = 4'h0;
          end
          lost_base = 16'd0;
        end

        // over-current trip and recovery
        if (curr_scaled > cfg_i.current_limit) begin
          if (cur_ext > trip_lim) begin
            enabled_d = 1'b0;
            duty_d    = DutyOff;
            cur_cnt_d = 16'sd0;
          end else if (cur_cnt_q != 16'sh7FFF) begin
            cur_cnt_d = cur_cnt_q + 16'sd1;
          end
        end else begin
          if (cur_ext < recover_lim) begin
            enabled_d = 1'b1;
            cur_cnt_d = 16'sd0;
          end else if (cur_cnt_q != 16'sh8000) begin
            cur_cnt_d = cur_cnt_q - 16'sd1;
          end
        end

        // fan hysteresis
        if (temp_scaled < cfg_i.temp_threshold) begin
          if (fan_ext > fan_up_lim) begin
            fan_cnt_d = 16'sd0;
            fan_d     = 1'b1;
          end else if (fan_cnt_q != 16'sh7FFF) begin
            fan_cnt_d = fan_cnt_q + 16'sd1;
          end
        end else begin
          if (fan_ext < fan_dn_lim) begin
            fan_cnt_d = 16'sd0;
            fan_d     = 1'b0;
          end else if (fan_cnt_q != 16'sh8000) begin
            fan_cnt_d = fan_cnt_q - 16'sd1;
          end
        end

        // lost signal timeout
        lost_fire = lost_base > cfg_i.signal_timeout;
        if (lost_fire) begin
          duty_d = DutyOff;
          lost_d = 16'd0;
        end else if (lost_base != 16'hFFFF) begin
          lost_d = lost_base + 16'd1;
        end else begin
          lost_d = lost_base;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hall_cnt_q  <= 16'd0;
      last_hall_q <= 16'd0;
      stalled_q   <= 1'b1;
      pulse_cnt_q <= 4'd0;
      held_q      <= 16'd0;
      new_pulse_q <= 1'b0;
      enabled_q   <= 1'b0;
      cur_cnt_q   <= 16'sd0;
      fan_cnt_q   <= 16'sd0;
      lost_q      <= 16'd0;
      duty_q      <= 8'd0;
      dir_q       <= 1'b0;
      phase_q     <= 4'h0;
      brake_q     <= 1'b0;
      fan_q       <= 1'b0;
    end else if (step_i) begin
      hall_cnt_q  <= hall_cnt_d;
      last_hall_q <= last_hall_d;
      stalled_q   <= stalled_d;
      pulse_cnt_q <= pulse_cnt_d;
      held_q      <= held_d;
      new_pulse_q <= new_pulse_d;
      enabled_q   <= enabled_d;
      cur_cnt_q   <= cur_cnt_d;
      fan_cnt_q   <= fan_cnt_d;
      lost_q      <= lost_d;
      duty_q      <= duty_d;
      dir_q       <= dir_d;
      phase_q     <= phase_d;
      brake_q     <= brake_d;
      fan_q       <= fan_d;
    end
  end

  always_comb begin
    result_o.duty          = duty_d;
    result_o.reverse       = dir_d;
    result_o.high_phase    = phase_d[3:2];
    result_o.low_phase     = phase_d[1:0];
    result_o.brake         = brake_d;
    result_o.fan_on        = fan_d;
    result_o.drive_enabled = enabled_d;
    result_o.start_request = start;
  end

endmodule

@@ design/sensored_bldc_speed_controller.sv @@
// Path: a beat waits in the input register until the output register has room,
// then its result is loaded there. Throughput: one beat per cycle while the
// consumer takes results; the input register refills while a result waits in
// the output register, so a stalled consumer only holds two beats.
// Reset (rst_ni, async, active low) clears all state, loads the default
// configuration and empties both registers; no clearing pass is needed.
module sensored_bldc_speed_controller import bldc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  input  logic [15:0]         pulse_width_i,
  input  logic [2:0]          hall_state_i,
  input  logic [7:0]          current_sample_i,
  input  logic [7:0]          temp_sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          duty_o,
  output logic                reverse_o,
  output logic [1:0]          high_phase_o,
  output logic [1:0]          low_phase_o,
  output logic                brake_o,
  output logic                fan_on_o,
  output logic                drive_enabled_o,
  output logic                start_request_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid_q, item_valid_d;
  result_t result;
  result_t res_q;
  logic    res_valid_q, res_valid_d;
  logic    advance;
  logic    in_fire;

  bldc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance    = item_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  bldc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_fire) begin
      item_valid_d = 1'b1;
    end else if (advance) begin
      item_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (advance) begin
      res_valid_d = 1'b1;
    end else if (out_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.cmd            <= cmd_e'(cmd_i);
      item_q.pulse_width    <= pulse_width_i;
      item_q.hall_state     <= hall_state_i;
      item_q.current_sample <= current_sample_i;
      item_q.temp_sample    <= temp_sample_i;
    end
    if (advance) begin
      res_q <= result;
    end
  end

  assign out_valid_o     = res_valid_q;
  assign duty_o          = res_q.duty;
  assign reverse_o       = res_q.reverse;
  assign high_phase_o    = res_q.high_phase;
  assign low_phase_o     = res_q.low_phase;
  assign brake_o         = res_q.brake;
  assign fan_on_o        = res_q.fan_on;
  assign drive_enabled_o = res_q.drive_enabled;
  assign start_request_o = res_q.start_request;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import bldc_pkg::*;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  logic [1:0]          cmd_i            = CMD_TICK;
  logic [15:0]         pulse_width_i    = '0;
  logic [2:0]          hall_state_i     = '0;
  logic [7:0]          current_sample_i = '0;
  logic [7:0]          temp_sample_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  logic [7:0]          duty_o;
  logic                reverse_o;
  logic [1:0]          high_phase_o;
  logic [1:0]          low_phase_o;
  logic                brake_o;
  logic                fan_on_o;
  logic                drive_enabled_o;
  logic                start_request_o;
  logic                cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i        = REG_PULSE_CENTRE;
  logic [CfgDataW-1:0] cfg_data_i       = '0;

  sensored_bldc_speed_controller DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .pulse_width_i   (pulse_width_i),
    .hall_state_i    (hall_state_i),
    .current_sample_i(current_sample_i),
    .temp_sample_i   (temp_sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .duty_o          (duty_o),
    .reverse_o       (reverse_o),
    .high_phase_o    (high_phase_o),
    .low_phase_o     (low_phase_o),
    .brake_o         (brake_o),
    .fan_on_o        (fan_on_o),
    .drive_enabled_o (drive_enabled_o),
    .start_request_o (start_request_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predicted controller state
  cfg_t        cfg_m;
  logic [15:0] hall_cnt, hall_at_check, width_held, lost_cnt;
  logic [3:0]  pulse_cnt;
  logic        stalled_f, pulse_seen, enabled_f, rev_q, brake_q, fan_q;
  logic [7:0]  duty_q;
  logic [3:0]  phase_q;
  int          oc_cnt, fan_cnt;

  result_t     drive_due[$];
  int          n_errors, n_sent, n_checked, n_starts, n_brakes;
  bit          steady, surge, hot;
  cfg_t        plan;

  function automatic void clear_drive_state();
    cfg_m.pulse_centre   = 16'd1500;
    cfg_m.current_limit  = 10'd720;
    cfg_m.trip_count     = 15'd650;
    cfg_m.recover_count  = 15'd20000;
    cfg_m.temp_threshold = 10'd362;
    cfg_m.fan_count      = 15'd2000;
    cfg_m.signal_timeout = 16'd12000;
    cfg_m.stall_check    = 5'd4;
    plan          = cfg_m;
    hall_cnt      = '0;
    hall_at_check = '0;
    width_held    = '0;
    lost_cnt      = '0;
    pulse_cnt     = '0;
    stalled_f     = 1'b1;
    pulse_seen    = 1'b0;
    enabled_f     = 1'b0;
    rev_q         = 1'b0;
    brake_q       = 1'b0;
    fan_q         = 1'b0;
    duty_q        = '0;
    phase_q       = '0;
    oc_cnt        = 0;
    fan_cnt       = 0;
  endfunction

  function automatic void store_reg(input reg_idx_e idx, input logic [15:0] val);
    case (idx)
      REG_PULSE_CENTRE:   cfg_m.pulse_centre   = val;
      REG_CURRENT_LIMIT:  cfg_m.current_limit  = val[9:0];
      REG_TRIP_COUNT:     cfg_m.trip_count     = val[14:0];
      REG_RECOVER_COUNT:  cfg_m.recover_count  = val[14:0];
      REG_TEMP_THRESHOLD: cfg_m.temp_threshold = val[9:0];
      REG_FAN_COUNT:      cfg_m.fan_count      = val[14:0];
      REG_SIGNAL_TIMEOUT: cfg_m.signal_timeout = val;
      default:            cfg_m.stall_check    = val[4:0];
    endcase
  endfunction

  function automatic logic [7:0] throttle(input int idx);
    if (idx >= 250) return 8'd255;
    if (idx >= 242) return 8'(239 + 2 * (idx - 242));
    if (idx >= 15) return 8'(idx - 4);
    if (idx >= 5) return 8'(6 + (idx - 5) / 2);
    return 8'(idx + 1);
  endfunction

  // reverse rotation reads the forward table mirrored
  function automatic logic [3:0] commutation(input logic rev, input logic [2:0] hs);
    logic [2:0] k;
    k = rev ? 3'd7 - hs : hs;
    case (k)
      3'd1:    return 4'h7;
      3'd2:    return 4'hE;
      3'd3:    return 4'h6;
      3'd4:    return 4'h9;
      3'd5:    return 4'hB;
      3'd6:    return 4'hD;
      default: return 4'h0;
    endcase
  endfunction

  function automatic result_t advance_drive(input item_t it);
    result_t    r;
    logic [3:0] code;
    logic [7:0] v;
    logic [9:0] amps, heat;
    logic       fire, kick;
    int         n, w_i, c_i, off, mag, trip, rec, fan_lim;
    kick = 1'b0;
    case (it.cmd)
      CMD_HALL: begin
        hall_cnt = hall_cnt + 16'd1;
        code = commutation(rev_q, it.hall_state);
        if (code != 4'h0) begin
          phase_q = code;
          brake_q = 1'b0;
        end
      end
      CMD_CAPTURE: begin
        n = cfg_m.stall_check;
        if (n < 1) n = 1;
        if (n > 16) n = 16;
        width_held = it.pulse_width;
        if (pulse_cnt >= n - 1) begin
          if (hall_at_check == hall_cnt) begin
            stalled_f = 1'b1;
          end else begin
            hall_at_check = hall_cnt;
            stalled_f = 1'b0;
          end
          pulse_cnt = '0;
        end else begin
          pulse_cnt = pulse_cnt + 4'd1;
        end
        if (hall_cnt > 16'd60000) hall_cnt = '0;
        pulse_seen = 1'b1;
      end
      CMD_TICK: begin
        amps = {it.current_sample, 2'b00};
        heat = {it.temp_sample, 2'b00};
        if (pulse_seen && enabled_f) begin
          w_i = width_held;
          c_i = cfg_m.pulse_centre;
          off = w_i - c_i;
          pulse_seen = 1'b0;
          rev_q = off < 0;
          mag = ((off < 0) ? -off : off) / 2;
          if (mag > 255) mag = 255;
          v = throttle(255 - mag);
          if (stalled_f && v != 8'd255) begin
            kick = 1'b1;
            stalled_f = 1'b0;
            pulse_cnt = '0;
          end
          duty_q = v;
          if (v == 8'd255) begin
            brake_q = 1'b1;
            phase_q = '0;
          end
          lost_cnt = '0;
        end
        trip = cfg_m.trip_count;
        rec = cfg_m.recover_count;
        fan_lim = cfg_m.fan_count;
        if (amps > cfg_m.current_limit) begin
          fire = oc_cnt > trip;
          if (oc_cnt < 32767) oc_cnt = oc_cnt + 1;
          if (fire) begin
            enabled_f = 1'b0;
            duty_q = 8'd255;
            oc_cnt = 0;
          end
        end else begin
          fire = oc_cnt < -rec;
          if (oc_cnt > -32768) oc_cnt = oc_cnt - 1;
          if (fire) begin
            enabled_f = 1'b1;
            oc_cnt = 0;
          end
        end
        if (heat < cfg_m.temp_threshold) begin
          fire = fan_cnt > fan_lim;
          if (fan_cnt < 32767) fan_cnt = fan_cnt + 1;
          if (fire) begin
            fan_cnt = 0;
            fan_q = 1'b1;
          end
        end else begin
          fire = fan_cnt < -fan_lim;
          if (fan_cnt > -32768) fan_cnt = fan_cnt - 1;
          if (fire) begin
            fan_cnt = 0;
            fan_q = 1'b0;
          end
        end
        fire = lost_cnt > cfg_m.signal_timeout;
        if (lost_cnt != 16'hFFFF) lost_cnt = lost_cnt + 16'd1;
        if (fire) begin
          duty_q = 8'd255;
          lost_cnt = '0;
        end
      end
      default: ;
    endcase
    r.duty          = duty_q;
    r.reverse       = rev_q;
    r.high_phase    = phase_q[3:2];
    r.low_phase     = phase_q[1:0];
    r.brake         = brake_q;
    r.fan_on        = fan_q;
    r.drive_enabled = enabled_f;
    r.start_request = kick;
    return r;
  endfunction

  function automatic void note_field(input string name, input logic [7:0] want,
                                     input logic [7:0] seen);
    if (seen !== want) begin
      n_errors++;
      if (n_errors <= 10)
        $display("%0t: %s mismatch, expected %0h got %0h", $realtime, name, want, seen);
    end
  endfunction

  function automatic void compare_drive(input result_t want, input result_t seen);
    note_field("duty", want.duty, seen.duty);
    note_field("reverse", want.reverse, seen.reverse);
    note_field("high_phase", want.high_phase, seen.high_phase);
    note_field("low_phase", want.low_phase, seen.low_phase);
    note_field("brake", want.brake, seen.brake);
    note_field("fan_on", want.fan_on, seen.fan_on);
    note_field("drive_enabled", want.drive_enabled, seen.drive_enabled);
    note_field("start_request", want.start_request, seen.start_request);
    n_checked++;
    if (want.start_request) n_starts++;
    if (want.brake) n_brakes++;
  endfunction

  always @(posedge clk_i) begin : watch
    item_t   taken;
    result_t seen;
    if (rst_ni) begin
      if (cfg_we_i) store_reg(reg_idx_e'(cfg_idx_i), cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        taken.cmd            = cmd_e'(cmd_i);
        taken.pulse_width    = pulse_width_i;
        taken.hall_state     = hall_state_i;
        taken.current_sample = current_sample_i;
        taken.temp_sample    = temp_sample_i;
        drive_due.push_back(advance_drive(taken));
        n_sent++;
      end
      if (out_valid_o && out_ready_i) begin
        seen.duty          = duty_o;
        seen.reverse       = reverse_o;
        seen.high_phase    = high_phase_o;
        seen.low_phase     = low_phase_o;
        seen.brake         = brake_o;
        seen.fan_on        = fan_on_o;
        seen.drive_enabled = drive_enabled_o;
        seen.start_request = start_request_o;
        if (drive_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("%0t: result beat with none expected", $realtime);
        end else begin
          compare_drive(drive_due.pop_front(), seen);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 20);
  end

  task automatic push_item(input cmd_e c, input logic [15:0] w, input logic [2:0] hs,
                           input logic [7:0] cur, input logic [7:0] tmp);
    if (!steady && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    cmd_i            <= c;
    pulse_width_i    <= w;
    hall_state_i     <= hs;
    current_sample_i <= cur;
    temp_sample_i    <= tmp;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic hall_beat(input logic [2:0] hs);
    push_item(CMD_HALL, 16'($urandom), hs, 8'($urandom), 8'($urandom));
  endtask

  task automatic capture_beat(input logic [15:0] w);
    push_item(CMD_CAPTURE, w, 3'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic tick_beat(input logic [7:0] cur, input logic [7:0] tmp);
    push_item(CMD_TICK, 16'($urandom), 3'($urandom), cur, tmp);
  endtask

  // hold off until every outstanding result is home
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (drive_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic apply_setup(input logic [15:0] centre, input logic [15:0] limit,
                             input logic [15:0] trip, input logic [15:0] recover,
                             input logic [15:0] temp, input logic [15:0] fan,
                             input logic [15:0] timeout, input logic [15:0] stall);
    settle();
    write_reg(REG_PULSE_CENTRE, centre);
    write_reg(REG_CURRENT_LIMIT, limit);
    write_reg(REG_TRIP_COUNT, trip);
    write_reg(REG_RECOVER_COUNT, recover);
    write_reg(REG_TEMP_THRESHOLD, temp);
    write_reg(REG_FAN_COUNT, fan);
    write_reg(REG_SIGNAL_TIMEOUT, timeout);
    write_reg(REG_STALL_CHECK, stall);
    cfg_we_i <= 1'b0;
    plan.pulse_centre   = centre;
    plan.current_limit  = limit[9:0];
    plan.temp_threshold = temp[9:0];
  endtask

  task automatic push_random();
    int         pick, w, cur_split, heat_split;
    logic [7:0] cur, tmp;
    pick = $urandom_range(99);
    cur_split = plan.current_limit / 4;
    heat_split = (plan.temp_threshold + 3) / 4;
    if (pick < 38) begin
      if (pick < 34) hall_beat(3'($urandom_range(6, 1)));
      else hall_beat($urandom_range(1) ? 3'd7 : 3'd0);
    end else if (pick < 58) begin
      case ($urandom_range(19))
        0, 1, 2:    w = $urandom_range(22) - 11;
        3, 4, 5, 6: w = $urandom_range(65535) - plan.pulse_centre;
        default:    w = $urandom_range(1400) - 700;
      endcase
      w = w + plan.pulse_centre;
      if (w < 0) w = 0;
      if (w > 65535) w = 65535;
      capture_beat(16'(w));
    end else if (pick < 96) begin
      if ($urandom_range(99) < 3) surge = !surge;
      if ($urandom_range(99) < 3) hot = !hot;
      if ($urandom_range(9) == 0) cur = 8'($urandom);
      else if (surge && cur_split < 255) cur = 8'($urandom_range(255, cur_split + 1));
      else cur = 8'($urandom_range(cur_split, 0));
      if (hot && heat_split <= 255) tmp = 8'($urandom_range(255, heat_split));
      else if (!hot && heat_split > 0) tmp = 8'($urandom_range(heat_split - 1, 0));
      else tmp = 8'($urandom);
      tick_beat(cur, tmp);
    end else begin
      push_item(CMD_IDLE, 16'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_directed();
    tick_beat(8'd255, 8'd0);
    push_item(CMD_IDLE, 16'hFFFF, 3'd7, 8'hFF, 8'hFF);
    apply_setup(16'd1500, 16'd400, 16'd2, 16'd1, 16'd362, 16'd1, 16'd8, 16'd1);
    repeat (4) tick_beat(8'd0, 8'd255);
    for (int h = 1; h <= 8; h++) hall_beat(3'(h));
    capture_beat(16'hFFFF);
    capture_beat(16'h0000);
    tick_beat(8'd0, 8'd0);
    hall_beat(3'd6);
    hall_beat(3'd0);
    capture_beat(16'd1500);
    tick_beat(8'd0, 8'd255);
    hall_beat(3'd2);
    repeat (4) tick_beat(8'd255, 8'd128);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_setup(16'd1500, 16'd400, 16'd6, 16'd3, 16'd362, 16'd5, 16'd30, 16'd4);
        1: apply_setup(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        2: apply_setup(16'hFFFF, 16'd1023, 16'd32767, 16'd32767, 16'd1023, 16'd32767,
                       16'hFFFF, 16'd31);
        3: apply_setup(16'd32768, 16'd512, 16'd20, 16'd10, 16'd600, 16'd12, 16'd200,
                       16'd16);
        default: apply_setup(16'($urandom), 16'($urandom_range(1023)),
                             16'($urandom_range(40)), 16'($urandom_range(40)),
                             16'($urandom_range(1023)), 16'($urandom_range(30)),
                             16'($urandom_range(300)), 16'($urandom_range(31)));
      endcase
      steady = (p == 3);
      for (int k = 0; k < 155; k++) begin
        if (p == 0 && k == 70) settle();
        push_random();
      end
    end
    steady = 1'b0;
  endtask

  initial begin : run
    int waited;
    clear_drive_state();
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_starts = 0;
    n_brakes = 0;
    steady = 1'b0;
    surge = 1'b0;
    hot = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phases();
    in_valid_i <= 1'b0;
    waited = 0;
    while (drive_due.size() != 0 && waited < 200) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (drive_due.size() != 0) begin
      $display("%0d expected results never arrived", drive_due.size());
      n_errors += drive_due.size();
    end
    $display("Run covered %0d beats in and %0d results checked over seven register setups,",
             n_sent, n_checked);
    $display("with %0d start requests and %0d braking results.",
             n_starts, n_brakes);
    if (n_errors == 0) begin
      $display("sensored_bldc_speed_controller regression: pass");
    end else begin
      $display("sensored_bldc_speed_controller regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("sensored_bldc_speed_controller regression: fail");
    $finish;
  end

endmodule
